>>> rtl/mandelbrot_escape_time_macros.svh
// assertion macros shared by the escape time engine
// clock and reset are the house port names
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

`ifndef ASSERT_OFF
// checked property, off while reset is high
`define MBE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked property, also during reset
`define MBE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MBE_ASSERT(label, prop, msg)
`define MBE_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/mbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

   // fixed field widths
   localparam int COORD_W    = 32;
   localparam int STEP_W     = 31;
   localparam int ITER_W     = 16;
   localparam int DIM_W      = 13;
   localparam int PIX_W      = 12;
   localparam int PROD_W     = 64;
   localparam int SUM_W      = 45;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // frame sizes above this count as this
   localparam int MAX_DIM = 4096;

   // default width of the iteration counter
   localparam int ITER_BITS_DEF = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_EDGE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_EDGE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_X       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_Y       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd6;

   // register reset values
   localparam logic signed [COORD_W-1:0] EDGE_RST  = -32'sd536870912;
   localparam logic [STEP_W-1:0]         STEP_RST  = 31'd2796202;
   localparam logic [ITER_W-1:0]         ITER_RST  = 16'd64;
   localparam logic [DIM_W-1:0]          FRAME_RST = 13'd600;

   // 4.0 in Q8.56
   localparam logic [PROD_W-1:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

   // controller to datapath
   typedef struct packed {
      logic load_in;
      logic map_coord;
      logic set_point;
      logic mult;
      logic step;
      logic load_out;
   } mbe_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic at_limit;
      logic escaped;
   } mbe_sts_type;

   // clip a wide signed sum to the Q4.28 range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if ((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1])) begin
         r = v[COORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/mandelbrot_escape_time.sv
`timescale 1ns / 1ps
`default_nettype none

// escape time engine for one pixel word at a time: the (col, row) word is mapped to
// c = (left_edge + col*step_x, top_edge + row*step_y) in signed Q4.28, then z = z*z + c
// is iterated from z = c until |z|^2 > 4 or max_iter iterations are done. the result word
// carries the count, an inside flag (limit reached) and a last pixel flag for the frame.
// one shared complex square unit does each iteration as a multiply state followed by an
// escape test and update state. the user must write the registers only while the engine
// is idle; the block itself does not enforce it. an output register holds the finished
// word, so the next pixel is taken while it waits.
module mandelbrot_escape_time #(
   parameter int ITER_BITS = mbe_pkg::ITER_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire logic [mbe_pkg::PIX_W-1:0]       req_col,
   input  wire logic [mbe_pkg::PIX_W-1:0]       req_row,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [mbe_pkg::ITER_W-1:0]           rsp_iterations,
   output logic                                 rsp_inside_res,
   output logic                                 rsp_last_pixel,
   input  wire                                  csr_we,
   input  wire logic [mbe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mbe_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   mbe_pkg::mbe_cmd_type cmd;
   mbe_pkg::mbe_sts_type sts;

   // sequencer
   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic and registers
   mbe_dpath #(
      .ITER_BITS (ITER_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_iterations (rsp_iterations),
      .rsp_inside_res (rsp_inside_res),
      .rsp_last_pixel (rsp_last_pixel),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule

`default_nettype wire

>>> rtl/mbe_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module mbe_dpath #(
   parameter int ITER_BITS = mbe_pkg::ITER_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire logic [mbe_pkg::PIX_W-1:0]       req_col,
   input  wire logic [mbe_pkg::PIX_W-1:0]       req_row,
   output logic [mbe_pkg::ITER_W-1:0]           rsp_iterations,
   output logic                                 rsp_inside_res,
   output logic                                 rsp_last_pixel,
   input  wire                                  csr_we,
   input  wire logic [mbe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mbe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire mbe_pkg::mbe_cmd_type            cmd,
   output mbe_pkg::mbe_sts_type                 sts
);

   localparam int PX_W = mbe_pkg::PIX_W + mbe_pkg::STEP_W;

   // configuration
   logic signed [mbe_pkg::COORD_W-1:0] left_edge_ff, left_edge_in;
   logic signed [mbe_pkg::COORD_W-1:0] top_edge_ff, top_edge_in;
   logic [mbe_pkg::STEP_W-1:0]         step_x_ff, step_x_in;
   logic [mbe_pkg::STEP_W-1:0]         step_y_ff, step_y_in;
   logic [mbe_pkg::ITER_W-1:0]         max_iter_ff, max_iter_in;
   logic [mbe_pkg::DIM_W-1:0]          frame_width_ff, frame_width_in;
   logic [mbe_pkg::DIM_W-1:0]          frame_height_ff, frame_height_in;

   // working registers
   logic [mbe_pkg::PIX_W-1:0]          col_ff, col_in;
   logic [mbe_pkg::PIX_W-1:0]          row_ff, row_in;
   logic                               last_ff, last_in;
   logic [PX_W-1:0]                    px_ff, px_in;
   logic [PX_W-1:0]                    py_ff, py_in;
   logic signed [mbe_pkg::COORD_W-1:0] cx_ff, cx_in;
   logic signed [mbe_pkg::COORD_W-1:0] cy_ff, cy_in;
   logic signed [mbe_pkg::COORD_W-1:0] zx_ff, zx_in;
   logic signed [mbe_pkg::COORD_W-1:0] zy_ff, zy_in;
   logic signed [mbe_pkg::PROD_W-1:0]  xx_ff, xx_in;
   logic signed [mbe_pkg::PROD_W-1:0]  yy_ff, yy_in;
   logic signed [mbe_pkg::PROD_W-1:0]  xy_ff, xy_in;
   logic [ITER_BITS-1:0]               iter_ff, iter_in;

   // result word
   logic [mbe_pkg::ITER_W-1:0]         out_iter_ff, out_iter_in;
   logic                               out_inside_ff, out_inside_in;
   logic                               out_last_ff, out_last_in;

   logic [mbe_pkg::DIM_W-1:0]          fw_clamp;
   logic [mbe_pkg::DIM_W-1:0]          fh_clamp;
   logic                               last_hit;
   logic [ITER_BITS-1:0]               limit;
   logic [mbe_pkg::ITER_W-1:0]         iter_out;
   logic signed [mbe_pkg::SUM_W-1:0]   cx_sum;
   logic signed [mbe_pkg::SUM_W-1:0]   cy_sum;
   logic signed [mbe_pkg::PROD_W-1:0]  diff;
   logic signed [mbe_pkg::SUM_W-1:0]   zx_sum;
   logic signed [mbe_pkg::SUM_W-1:0]   zy_sum;
   logic [mbe_pkg::PROD_W-1:0]         mag;

   // limit is max_iter cut to the counter width
   for (genvar k = 0; k < ITER_BITS; k++) begin : g_limit
      if (k < mbe_pkg::ITER_W) begin : g_bit
         assign limit[k] = max_iter_ff[k];
      end else begin : g_zero
         assign limit[k] = 1'b0;
      end
   end

   // counter seen through the 16 bit result field
   for (genvar k = 0; k < mbe_pkg::ITER_W; k++) begin : g_iter_out
      if (k < ITER_BITS) begin : g_bit
         assign iter_out[k] = iter_ff[k];
      end else begin : g_zero
         assign iter_out[k] = 1'b0;
      end
   end

   // last pixel of the frame, sizes clipped to the largest frame
   always_comb begin
      fw_clamp = (frame_width_ff > mbe_pkg::DIM_W'(mbe_pkg::MAX_DIM))
               ? mbe_pkg::DIM_W'(mbe_pkg::MAX_DIM) : frame_width_ff;
      fh_clamp = (frame_height_ff > mbe_pkg::DIM_W'(mbe_pkg::MAX_DIM))
               ? mbe_pkg::DIM_W'(mbe_pkg::MAX_DIM) : frame_height_ff;
      last_hit = (fw_clamp != '0) && (fh_clamp != '0)
              && ({1'b0, req_col} == (fw_clamp - 1'b1))
              && ({1'b0, req_row} == (fh_clamp - 1'b1));
   end

   // point mapping, escape test and z update arithmetic
   always_comb begin
      cx_sum = mbe_pkg::SUM_W'(left_edge_ff) + $signed({2'b00, px_ff});
      cy_sum = mbe_pkg::SUM_W'(top_edge_ff) + $signed({2'b00, py_ff});
      diff   = xx_ff - yy_ff;
      zx_sum = mbe_pkg::SUM_W'($signed(diff[mbe_pkg::PROD_W-1:28]))
             + mbe_pkg::SUM_W'(cx_ff);
      zy_sum = mbe_pkg::SUM_W'($signed(xy_ff[mbe_pkg::PROD_W-1:27]))
             + mbe_pkg::SUM_W'(cy_ff);
      mag    = $unsigned(xx_ff) + $unsigned(yy_ff);
   end

   assign sts.at_limit = (iter_ff == limit);
   assign sts.escaped  = (mag > mbe_pkg::ESCAPE_LIMIT);

   // configuration writes
   always_comb begin
      left_edge_in    = left_edge_ff;
      top_edge_in     = top_edge_ff;
      step_x_in       = step_x_ff;
      step_y_in       = step_y_ff;
      max_iter_in     = max_iter_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         case (csr_index)
            mbe_pkg::CSR_LEFT_EDGE:    left_edge_in    = $signed(csr_wdata);
            mbe_pkg::CSR_TOP_EDGE:     top_edge_in     = $signed(csr_wdata);
            mbe_pkg::CSR_STEP_X:       step_x_in       = csr_wdata[mbe_pkg::STEP_W-1:0];
            mbe_pkg::CSR_STEP_Y:       step_y_in       = csr_wdata[mbe_pkg::STEP_W-1:0];
            mbe_pkg::CSR_MAX_ITER:     max_iter_in     = csr_wdata[mbe_pkg::ITER_W-1:0];
            mbe_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata[mbe_pkg::DIM_W-1:0];
            mbe_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[mbe_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_edge_ff    <= mbe_pkg::EDGE_RST;
         top_edge_ff     <= mbe_pkg::EDGE_RST;
         step_x_ff       <= mbe_pkg::STEP_RST;
         step_y_ff       <= mbe_pkg::STEP_RST;
         max_iter_ff     <= mbe_pkg::ITER_RST;
         frame_width_ff  <= mbe_pkg::FRAME_RST;
         frame_height_ff <= mbe_pkg::FRAME_RST;
      end else begin
         left_edge_ff    <= left_edge_in;
         top_edge_ff     <= top_edge_in;
         step_x_ff       <= step_x_in;
         step_y_ff       <= step_y_in;
         max_iter_ff     <= max_iter_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // working register updates, one command at a time
   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      last_in       = last_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      zx_in         = zx_ff;
      zy_in         = zy_ff;
      xx_in         = xx_ff;
      yy_in         = yy_ff;
      xy_in         = xy_ff;
      iter_in       = iter_ff;
      out_iter_in   = out_iter_ff;
      out_inside_in = out_inside_ff;
      out_last_in   = out_last_ff;

      // capture the pixel word
      if (cmd.load_in) begin
         col_in  = req_col;
         row_in  = req_row;
         last_in = last_hit;
      end

      // column and row scaled by the step
      if (cmd.map_coord) begin
         px_in = col_ff * step_x_ff;
         py_in = row_ff * step_y_ff;
      end

      // c from the edges, z starts at c
      if (cmd.set_point) begin
         cx_in   = mbe_pkg::sat_coord(cx_sum);
         cy_in   = mbe_pkg::sat_coord(cy_sum);
         zx_in   = mbe_pkg::sat_coord(cx_sum);
         zy_in   = mbe_pkg::sat_coord(cy_sum);
         iter_in = '0;
      end

      // squares and cross product of z
      if (cmd.mult) begin
         xx_in = zx_ff * zx_ff;
         yy_in = zy_ff * zy_ff;
         xy_in = zx_ff * zy_ff;
      end

      // z = z*z + c
      if (cmd.step) begin
         zx_in   = mbe_pkg::sat_coord(zx_sum);
         zy_in   = mbe_pkg::sat_coord(zy_sum);
         iter_in = iter_ff + {{(ITER_BITS-1){1'b0}}, 1'b1};
      end

      // result word into the output register
      if (cmd.load_out) begin
         out_iter_in   = iter_out;
         out_inside_in = sts.at_limit;
         out_last_in   = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      row_ff        <= row_in;
      last_ff       <= last_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      zx_ff         <= zx_in;
      zy_ff         <= zy_in;
      xx_ff         <= xx_in;
      yy_ff         <= yy_in;
      xy_ff         <= xy_in;
      iter_ff       <= iter_in;
      out_iter_ff   <= out_iter_in;
      out_inside_ff <= out_inside_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_iterations = out_iter_ff;
   assign rsp_inside_res = out_inside_ff;
   assign rsp_last_pixel = out_last_ff;

endmodule

`default_nettype wire

>>> rtl/mbe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_escape_time_macros.svh"

module mbe_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   input  wire mbe_pkg::mbe_sts_type    sts,
   output mbe_pkg::mbe_cmd_type         cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MAP  = 3'd1;
   localparam logic [2:0] S_CSET = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_UPD  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // output register can take a word when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_MAP;
            end
         end
         S_MAP: begin
            cmd.map_coord = 1'b1;
            state_in      = S_CSET;
         end
         S_CSET: begin
            cmd.set_point = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            if (sts.at_limit) begin
               state_in = S_FIN;
            end else begin
               cmd.mult = 1'b1;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (sts.escaped) begin
               state_in = S_FIN;
            end else begin
               cmd.step = 1'b1;
               state_in = S_MUL;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // an accepted word always goes on to the mapping step
   `MBE_ASSERT(a_accept_to_map, req_valid && !req_stall |=> state_ff == S_MAP, "accept did not start mapping")
   // never overwrite a result that is still waiting
   `MBE_ASSERT(a_no_overwrite, cmd.load_out |-> !rsp_valid_ff || !rsp_stall, "pending result overwritten")
   // an update is only reached below the limit and straight after a multiply
   `MBE_ASSERT(a_upd_below_limit, state_ff == S_UPD |-> !sts.at_limit && $past(state_ff) == S_MUL, "update past the limit")
   // reset leaves the engine idle with no result
   `MBE_ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == S_IDLE && !rsp_valid_ff, "reset did not clear control")

endmodule

`default_nettype wire
